/* rtl/ntre_pkg.sv */
`default_nettype none

package ntre_pkg;

  // One input item: a raw tag byte and the start-of-buffer mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } ntre_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_valid;
    logic       done_res;
    logic       status;
  } ntre_out_t;

  // Parse phases, one-hot.
  typedef enum logic [15:0] {
    PH_IDLE          = 16'b0000_0000_0000_0001,
    PH_TLV_TYPE      = 16'b0000_0000_0000_0010,
    PH_TLV_LEN       = 16'b0000_0000_0000_0100,
    PH_TLV_LEN_EXT   = 16'b0000_0000_0000_1000,
    PH_TLV_SKIP      = 16'b0000_0000_0001_0000,
    PH_REC_HDR       = 16'b0000_0000_0010_0000,
    PH_REC_TYPELEN   = 16'b0000_0000_0100_0000,
    PH_REC_PLEN      = 16'b0000_0000_1000_0000,
    PH_REC_IDLEN     = 16'b0000_0001_0000_0000,
    PH_REC_SKIP_ID   = 16'b0000_0010_0000_0000,
    PH_REC_TYPE      = 16'b0000_0100_0000_0000,
    PH_REC_SKIP_PAY  = 16'b0000_1000_0000_0000,
    PH_REC_STATUS    = 16'b0001_0000_0000_0000,
    PH_REC_SKIP_LANG = 16'b0010_0000_0000_0000,
    PH_TEXT          = 16'b0100_0000_0000_0000,
    PH_STOP          = 16'b1000_0000_0000_0000
  } ntre_phase_t;

  // Complete parser state carried from one byte to the next.
  typedef struct packed {
    ntre_phase_t phase;
    logic [7:0]  pos;
    logic [15:0] tlv_length;
    logic [8:0]  message_end;
    logic [4:0]  record_flags;
    logic [7:0]  type_length;
    logic [31:0] payload_length;
    logic [31:0] skip_count;
    logic        type_is_t;
    logic [31:0] text_remaining;
    logic        text_found;
    logic        tlv_ndef;
  } ntre_state_t;

  // TLV type codes and length escape.
  localparam logic [7:0] TLV_NULL    = 8'h00;
  localparam logic [7:0] TLV_NDEF    = 8'h03;
  localparam logic [7:0] TLV_TERM    = 8'hFE;
  localparam logic [7:0] TLV_LEN_ESC = 8'hFF;

  // Record header bits.
  localparam int unsigned HDR_SR_BIT = 4;
  localparam int unsigned HDR_IL_BIT = 3;
  localparam logic [2:0]  TNF_WELL_KNOWN = 3'd1;
  localparam logic [7:0]  TYPE_TEXT = 8'h54;

  localparam logic [7:0] BUF_LEN_RESET = 8'd64;

  // State after reset, and at the start of every buffer before the phase is set.
  function automatic ntre_state_t ntre_clear();
    ntre_state_t s;
    s.phase          = PH_IDLE;
    s.pos            = '0;
    s.tlv_length     = '0;
    s.message_end    = '0;
    s.record_flags   = '0;
    s.type_length    = '0;
    s.payload_length = '0;
    s.skip_count     = '0;
    s.type_is_t      = 1'b0;
    s.text_remaining = '0;
    s.text_found     = 1'b0;
    s.tlv_ndef       = 1'b0;
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/ntre_step.sv */
`default_nettype none

// Next-state and result logic for one tag byte.
module ntre_step import ntre_pkg::*; (
  input  ntre_state_t cur,
  input  logic [8:0]  eff,
  input  ntre_in_t    item,
  output ntre_state_t nxt,
  output logic        emit,
  output ntre_out_t   res
);

  // A TLV length is complete: skip a foreign TLV or open the NDEF message.
  function automatic ntre_state_t tlv_known(ntre_state_t s, logic [8:0] next_pos,
                                            logic [8:0] eff_len);
    logic [16:0] msg_sum;
    msg_sum = {8'd0, next_pos} + {1'b0, s.tlv_length};
    if (!s.tlv_ndef) begin
      s.skip_count = {16'd0, s.tlv_length};
      s.phase = (s.tlv_length != '0) ? PH_TLV_SKIP : PH_TLV_TYPE;
    end else if (msg_sum > {8'd0, eff_len} || s.tlv_length == '0) begin
      s.phase = PH_STOP;
    end else begin
      s.message_end = msg_sum[8:0];
      s.phase = PH_REC_HDR;
    end
    return s;
  endfunction

  // After the type field: select the text record or skip the payload.
  function automatic ntre_state_t decide(ntre_state_t s);
    if (s.record_flags[2:0] == TNF_WELL_KNOWN && s.type_length == 8'd1 &&
        s.type_is_t && s.payload_length != '0) begin
      s.phase = PH_REC_STATUS;
    end else begin
      s.skip_count = s.payload_length;
      s.phase = (s.payload_length != '0) ? PH_REC_SKIP_PAY : PH_REC_HDR;
    end
    return s;
  endfunction

  function automatic ntre_state_t start_type(ntre_state_t s);
    s.skip_count = {24'd0, s.type_length};
    if (s.type_length == '0) begin
      s = decide(s);
    end else begin
      s.phase = PH_REC_TYPE;
    end
    return s;
  endfunction

  function automatic ntre_state_t text_or_stop(ntre_state_t s);
    s.phase = (s.text_remaining != '0) ? PH_TEXT : PH_STOP;
    return s;
  endfunction

  ntre_state_t s;
  logic        active;
  logic        last;
  logic        tv;
  logic [8:0]  next_pos;
  logic [31:0] skip_dec;
  logic [31:0] text_dec;
  logic [31:0] body;
  logic [31:0] lang_ext;
  logic [5:0]  lang;

  always_comb begin
    s = cur;
    if (item.first) begin
      s = ntre_clear();
      s.phase = PH_TLV_TYPE;
    end
    active   = item.first || (cur.phase != PH_IDLE);
    next_pos = {1'b0, s.pos} + 9'd1;
    skip_dec = s.skip_count - 32'd1;
    text_dec = s.text_remaining - 32'd1;
    lang     = item.data_byte[5:0];
    lang_ext = {26'd0, lang};
    body     = s.payload_length - 32'd1;
    last     = 1'b0;
    tv       = 1'b0;

    if (active) begin
      if ({1'b0, s.pos} >= eff) begin
        // Byte past the end of the buffer: dropped, parser goes idle.
        s.phase = PH_IDLE;
      end else begin
        case (s.phase)
          PH_TLV_TYPE: begin
            if (item.data_byte == TLV_TERM) begin
              s.phase = PH_STOP;
            end else if (item.data_byte != TLV_NULL) begin
              s.tlv_ndef = (item.data_byte == TLV_NDEF);
              s.phase = PH_TLV_LEN;
            end
          end
          PH_TLV_LEN: begin
            if (item.data_byte == TLV_LEN_ESC) begin
              s.tlv_length = '0;
              s.skip_count = 32'd2;
              s.phase = PH_TLV_LEN_EXT;
            end else begin
              s.tlv_length = {8'd0, item.data_byte};
              s = tlv_known(s, next_pos, eff);
            end
          end
          PH_TLV_LEN_EXT: begin
            s.tlv_length = {s.tlv_length[7:0], item.data_byte};
            s.skip_count = skip_dec;
            if (skip_dec == '0) begin
              s = tlv_known(s, next_pos, eff);
            end
          end
          PH_TLV_SKIP: begin
            s.skip_count = skip_dec;
            if (skip_dec == '0) begin
              s.phase = PH_TLV_TYPE;
            end
          end
          PH_REC_HDR: begin
            if ({1'b0, s.pos} >= s.message_end) begin
              s.phase = PH_STOP;
            end else begin
              s.record_flags = item.data_byte[4:0];
              s.type_is_t = 1'b0;
              s.payload_length = '0;
              s.phase = PH_REC_TYPELEN;
            end
          end
          PH_REC_TYPELEN: begin
            s.type_length = item.data_byte;
            s.skip_count = s.record_flags[HDR_SR_BIT] ? 32'd1 : 32'd4;
            s.phase = PH_REC_PLEN;
          end
          PH_REC_PLEN: begin
            s.payload_length = {s.payload_length[23:0], item.data_byte};
            s.skip_count = skip_dec;
            if (skip_dec == '0) begin
              if (s.record_flags[HDR_IL_BIT]) begin
                s.phase = PH_REC_IDLEN;
              end else begin
                s = start_type(s);
              end
            end
          end
          PH_REC_IDLEN: begin
            s.skip_count = {24'd0, item.data_byte};
            if (item.data_byte != '0) begin
              s.phase = PH_REC_SKIP_ID;
            end else begin
              s = start_type(s);
            end
          end
          PH_REC_SKIP_ID: begin
            s.skip_count = skip_dec;
            if (skip_dec == '0) begin
              s = start_type(s);
            end
          end
          PH_REC_TYPE: begin
            // Only the first type byte can make the type a 'T'.
            if (s.skip_count == {24'd0, s.type_length} && item.data_byte == TYPE_TEXT) begin
              s.type_is_t = 1'b1;
            end
            s.skip_count = skip_dec;
            if (skip_dec == '0) begin
              s = decide(s);
            end
          end
          PH_REC_SKIP_PAY: begin
            s.skip_count = skip_dec;
            if (skip_dec == '0) begin
              s.phase = PH_REC_HDR;
            end
          end
          PH_REC_STATUS: begin
            // Status byte: language code length sets the bytes to skip.
            s.text_found = 1'b1;
            s.text_remaining = (body > lang_ext) ? (body - lang_ext) : 32'd0;
            s.skip_count = lang_ext;
            if (lang != '0) begin
              s.phase = PH_REC_SKIP_LANG;
            end else begin
              s = text_or_stop(s);
            end
          end
          PH_REC_SKIP_LANG: begin
            s.skip_count = skip_dec;
            if (skip_dec == '0) begin
              s = text_or_stop(s);
            end
          end
          PH_TEXT: begin
            tv = 1'b1;
            s.text_remaining = text_dec;
            if (text_dec == '0) begin
              s.phase = PH_STOP;
            end
          end
          default: begin
          end
        endcase

        last  = (next_pos == eff);
        s.pos = next_pos[7:0];
        if (last) begin
          s.phase = PH_IDLE;
        end
      end
    end

    nxt            = s;
    emit           = tv || last;
    res.text_byte  = tv ? item.data_byte : 8'd0;
    res.text_valid = tv;
    res.done_res   = last;
    res.status     = last && s.text_found;
  end

endmodule

`default_nettype wire

/* rtl/ndef_text_record_extractor.sv */
`default_nettype none

// Extracts the text of the first Well Known 'T' record from a stream of tag
// user-memory bytes. Each byte is one input item, and in_data.first opens a new
// buffer whose length is the value last written to cfg_wdata (capped at
// MAX_BYTES). The block takes one byte per clock cycle while in_ready is high;
// each byte passes through a combinational parse step into the output register,
// so a result appears in the cycle after its byte is accepted, and a new byte is
// accepted while the output register is empty or being drained. A byte yields a
// result only when it is a text character or the last byte of the buffer; the
// last byte carries done_res, with status set if a text record was found. Bytes
// outside a started buffer are dropped silently. There is no clearing pass after
// reset, and cfg_wdata must only be written while the block is idle.
module ndef_text_record_extractor import ntre_pkg::*; #(
  parameter int unsigned MAX_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ntre_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ntre_out_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam logic [8:0] MaxEff = 9'(MAX_BYTES);

  logic [7:0]  buffer_length;
  logic [8:0]  eff;
  ntre_state_t state;
  ntre_state_t state_next;
  logic        step_emit;
  ntre_out_t   step_res;
  logic        in_accept;

  // Buffer length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= BUF_LEN_RESET;
    end else if (cfg_we) begin
      buffer_length <= cfg_wdata;
    end
  end

  assign eff = ({1'b0, buffer_length} > MaxEff) ? MaxEff : {1'b0, buffer_length};

  // Input is taken whenever the output register can hold the next result.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  ntre_step u_step (
    .cur  (state),
    .eff  (eff),
    .item (in_data),
    .nxt  (state_next),
    .emit (step_emit),
    .res  (step_res)
  );

  // Parser state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntre_clear();
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && step_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && step_emit) begin
      out_data <= step_res;
    end
  end

  // A held result is always either a text character or the end of a buffer.
  a_out_meaningful: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.text_valid || out_data.done_res))
    else $error("result item carries neither text nor done");

  // A found status is only reported on the done item.
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |-> out_data.done_res)
    else $error("status set without done");

  // The last byte of a buffer always leaves the parser idle.
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    (in_accept && step_emit && step_res.done_res) |=> (state.phase == PH_IDLE))
    else $error("parser not idle after done");

  // Text is only produced from the text phase of a running buffer.
  a_text_from_text_phase: assert property (@(posedge clk) disable iff (rst)
    (in_accept && step_res.text_valid) |-> (state.phase == PH_TEXT && !in_data.first))
    else $error("text byte outside the text phase");

endmodule

`default_nettype wire

/* tb/ndef_text_record_extractor_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the buffer length port of the extractor, keeps its
// own copy of the parser state, and compares every result item with the
// oldest expected one.
module ndef_text_record_extractor_checker import ntre_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  ntre_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  ntre_out_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  output int        fail_count,
  output int        pending_count
);

  // Shadow copy of the parser state and the buffer length register.
  ntre_phase_t phase;
  logic [7:0]  byte_pos;
  logic [15:0] tlv_len;
  logic [8:0]  msg_end;
  logic [4:0]  hdr_flags;
  logic [7:0]  type_len;
  logic [31:0] pay_len;
  logic [31:0] count_down;
  logic        saw_t;
  logic [31:0] text_left;
  logic        found_text;
  logic        in_ndef;
  logic [7:0]  buf_len;

  // Text characters and done markers still to come out of the block.
  ntre_out_t expected_text_q[$];

  int fails = 0;
  int waiting = 0;

  assign fail_count    = fails;
  assign pending_count = waiting;

  function automatic void restart_parse();
    phase      = PH_IDLE;
    byte_pos   = '0;
    tlv_len    = '0;
    msg_end    = '0;
    hdr_flags  = '0;
    type_len   = '0;
    pay_len    = '0;
    count_down = '0;
    saw_t      = 1'b0;
    text_left  = '0;
    found_text = 1'b0;
    in_ndef    = 1'b0;
  endfunction

  // A TLV length is complete: skip a foreign TLV, or open the NDEF message.
  function automatic void tlv_len_done(input int unsigned pos);
    int unsigned next;
    next = pos + 1;
    if (!in_ndef) begin
      count_down = 32'(tlv_len);
      phase = (tlv_len != 0) ? PH_TLV_SKIP : PH_TLV_TYPE;
    end else if (next + tlv_len > buf_len || tlv_len == 0) begin
      phase = PH_STOP;
    end else begin
      msg_end = 9'(next + tlv_len);
      phase = PH_REC_HDR;
    end
  endfunction

  // The record type is known: enter the text record or skip the payload.
  function automatic void pick_record();
    if (hdr_flags[2:0] == TNF_WELL_KNOWN && type_len == 1 && saw_t && pay_len != 0) begin
      phase = PH_REC_STATUS;
    end else begin
      count_down = pay_len;
      phase = (pay_len != 0) ? PH_REC_SKIP_PAY : PH_REC_HDR;
    end
  endfunction

  function automatic void enter_type();
    count_down = 32'(type_len);
    if (type_len == 0) begin
      pick_record();
    end else begin
      phase = PH_REC_TYPE;
    end
  endfunction

  function automatic void lang_done();
    phase = (text_left != 0) ? PH_TEXT : PH_STOP;
  endfunction

  // Advances the shadow parser by one tag byte; returns 1 when a result item
  // is due, with that item in res.
  function automatic bit parse_tag_byte(input ntre_in_t item, output ntre_out_t res);
    logic [7:0]  b;
    int unsigned pos;
    logic [7:0]  tb;
    bit          tv;
    bit          last;
    logic [31:0] lang;
    logic [31:0] body;
    b   = item.data_byte;
    tb  = '0;
    tv  = 1'b0;
    res = '0;
    if (item.first) begin
      restart_parse();
      phase = PH_TLV_TYPE;
    end else if (phase == PH_IDLE) begin
      return 1'b0;
    end
    pos = byte_pos;
    if (pos >= buf_len) begin
      phase = PH_IDLE;
      return 1'b0;
    end

    case (phase)
      PH_TLV_TYPE: begin
        if (b == TLV_TERM) begin
          phase = PH_STOP;
        end else if (b != TLV_NULL) begin
          in_ndef = (b == TLV_NDEF);
          phase = PH_TLV_LEN;
        end
      end
      PH_TLV_LEN: begin
        if (b == TLV_LEN_ESC) begin
          tlv_len = '0;
          count_down = 2;
          phase = PH_TLV_LEN_EXT;
        end else begin
          tlv_len = 16'(b);
          tlv_len_done(pos);
        end
      end
      PH_TLV_LEN_EXT: begin
        tlv_len = {tlv_len[7:0], b};
        count_down = count_down - 1;
        if (count_down == 0) tlv_len_done(pos);
      end
      PH_TLV_SKIP: begin
        count_down = count_down - 1;
        if (count_down == 0) phase = PH_TLV_TYPE;
      end
      PH_REC_HDR: begin
        if (pos >= msg_end) begin
          phase = PH_STOP;
        end else begin
          hdr_flags = b[4:0];
          saw_t = 1'b0;
          pay_len = '0;
          phase = PH_REC_TYPELEN;
        end
      end
      PH_REC_TYPELEN: begin
        type_len = b;
        count_down = hdr_flags[HDR_SR_BIT] ? 32'd1 : 32'd4;
        phase = PH_REC_PLEN;
      end
      PH_REC_PLEN: begin
        pay_len = {pay_len[23:0], b};
        count_down = count_down - 1;
        if (count_down == 0) begin
          if (hdr_flags[HDR_IL_BIT]) begin
            phase = PH_REC_IDLEN;
          end else begin
            enter_type();
          end
        end
      end
      PH_REC_IDLEN: begin
        count_down = 32'(b);
        if (b != 0) begin
          phase = PH_REC_SKIP_ID;
        end else begin
          enter_type();
        end
      end
      PH_REC_SKIP_ID: begin
        count_down = count_down - 1;
        if (count_down == 0) enter_type();
      end
      PH_REC_TYPE: begin
        // Only the first type byte can mark a text record.
        if (count_down == 32'(type_len) && b == TYPE_TEXT) saw_t = 1'b1;
        count_down = count_down - 1;
        if (count_down == 0) pick_record();
      end
      PH_REC_SKIP_PAY: begin
        count_down = count_down - 1;
        if (count_down == 0) phase = PH_REC_HDR;
      end
      PH_REC_STATUS: begin
        // The status byte carries the language code length in its low six bits.
        lang = 32'(b[5:0]);
        body = pay_len - 1;
        found_text = 1'b1;
        text_left = (body > lang) ? body - lang : 32'd0;
        count_down = lang;
        if (lang != 0) begin
          phase = PH_REC_SKIP_LANG;
        end else begin
          lang_done();
        end
      end
      PH_REC_SKIP_LANG: begin
        count_down = count_down - 1;
        if (count_down == 0) lang_done();
      end
      PH_TEXT: begin
        tb = b;
        tv = 1'b1;
        text_left = text_left - 1;
        if (text_left == 0) phase = PH_STOP;
      end
      default: begin
      end
    endcase

    last = (pos + 1 == buf_len);
    byte_pos = 8'(pos + 1);
    if (last) phase = PH_IDLE;
    if (!tv && !last) return 1'b0;
    res.text_byte  = tb;
    res.text_valid = tv;
    res.done_res   = last;
    res.status     = last && found_text;
    return 1'b1;
  endfunction

  // Check result items, predict for accepted bytes, and track register writes.
  always @(posedge clk) begin : watch_channels
    ntre_out_t want;
    ntre_out_t pred;
    int        new_fails;
    new_fails = 0;
    if (rst) begin
      restart_parse();
      buf_len = BUF_LEN_RESET;
      expected_text_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_text_q.size() == 0) begin
          $error("unexpected result item: text_byte %0h text_valid %0b done_res %0b status %0b",
                 out_data.text_byte, out_data.text_valid, out_data.done_res, out_data.status);
          new_fails++;
        end else begin
          want = expected_text_q.pop_front();
          if (out_data.text_byte !== want.text_byte) begin
            $error("text_byte: expected %0h, actual %0h", want.text_byte, out_data.text_byte);
            new_fails++;
          end
          if (out_data.text_valid !== want.text_valid) begin
            $error("text_valid: expected %0b, actual %0b", want.text_valid, out_data.text_valid);
            new_fails++;
          end
          if (out_data.done_res !== want.done_res) begin
            $error("done_res: expected %0b, actual %0b", want.done_res, out_data.done_res);
            new_fails++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, out_data.status);
            new_fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (parse_tag_byte(in_data, pred)) expected_text_q.push_back(pred);
      end
      if (cfg_we) buf_len = cfg_wdata;
    end
    fails   <= fails + new_fails;
    waiting <= expected_text_q.size();
  end

endmodule

/* tb/ndef_text_record_extractor_tb.sv */
`timescale 1ns / 1ps

// Drives tag images through the extractor: a few directed buffers, then
// phases of random NDEF images at different buffer lengths.
module ndef_text_record_extractor_tb;
  import ntre_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int TARGET_BYTES = 1200;
  localparam int QUIET_AFTER = 1000;
  localparam int HOLD_AFTER = 500;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] LOCK_CTRL_TLV = 8'h01;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  ntre_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  ntre_out_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int fail_count;
  int pending_count;

  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int bytes_sent = 0;

  // Bytes of the tag image being sent.
  logic [7:0] tag_image[$];

  ndef_text_record_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ndef_text_record_extractor_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b1;
    #(CLK_PERIOD / 2);
    clk = 1'b0;
    #(CLK_PERIOD / 2);
  end

  // Result side: random stalls, one long hold-off, none near the end.
  initial begin : result_sink
    int hold_left;
    forever begin
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one byte, with an optional gap first, and waits until it is taken.
  task automatic offer_byte(input logic [7:0] b, input bit start);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, first: start};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every expected item has come out.
  task automatic settle_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_buffer_length(input logic [7:0] len);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sends the image as one buffer; bytes inside the buffer length count.
  task automatic send_image(input int len);
    for (int i = 0; i < tag_image.size(); i++) begin
      offer_byte(tag_image[i], i == 0);
      if (i < len) bytes_sent++;
      if (bytes_sent >= HOLD_AFTER) hold_request = 1'b1;
    end
  endtask

  // Builds a tag image: up to two null or foreign TLVs, one NDEF TLV holding one to
  // three records (mostly text records), and sometimes a terminator.
  task automatic build_ndef_image();
    logic [7:0] msg[$];
    logic [7:0] pay[$];
    logic [7:0] hdr;
    logic [7:0] tlv_t;
    logic [7:0] status_b;
    int tlv_n;
    int lang_n;
    int text_n;
    int type_n;
    int id_n;
    int ndef_len;
    bit is_text;
    bit sr;
    bit il;
    tag_image = {};
    msg = {};

    // Leading null and foreign TLVs.
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) == 0) begin
        tag_image.push_back(TLV_NULL);
      end else begin
        tlv_t = 8'($urandom_range(1, 255));
        if (tlv_t == TLV_NDEF || tlv_t == TLV_TERM) tlv_t = LOCK_CTRL_TLV;
        tlv_n = $urandom_range(0, 4);
        tag_image.push_back(tlv_t);
        if ($urandom_range(0, 3) == 0) begin
          tag_image.push_back(TLV_LEN_ESC);
          tag_image.push_back(8'h00);
        end
        tag_image.push_back(8'(tlv_n));
        repeat (tlv_n) tag_image.push_back(8'($urandom_range(0, 255)));
      end
    end

    // Records of the NDEF message.
    repeat ($urandom_range(1, 3)) begin
      is_text = ($urandom_range(0, 2) != 0);
      sr = ($urandom_range(0, 4) != 0);
      il = ($urandom_range(0, 3) == 0);
      hdr = 8'($urandom_range(0, 255));
      hdr[HDR_SR_BIT] = sr;
      hdr[HDR_IL_BIT] = il;
      if (is_text) hdr[2:0] = TNF_WELL_KNOWN;
      type_n = is_text ? 1 : $urandom_range(0, 3);

      pay = {};
      if (is_text) begin
        lang_n = $urandom_range(0, 5);
        text_n = $urandom_range(0, 16);
        status_b = {2'($urandom_range(0, 3)), 6'(lang_n)};
        // Now and then the language length claims more than the payload holds.
        if ($urandom_range(0, 7) == 0) status_b[5:0] = 6'($urandom_range(0, 63));
        pay.push_back(status_b);
        repeat (lang_n) pay.push_back(8'($urandom_range(97, 122)));
        repeat (text_n) pay.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 6)) pay.push_back(8'($urandom_range(0, 255)));
      end

      msg.push_back(hdr);
      msg.push_back(8'(type_n));
      if (!sr) begin
        repeat (3) msg.push_back(8'h00);
      end
      msg.push_back(8'(pay.size()));
      if (il) begin
        id_n = $urandom_range(0, 3);
        msg.push_back(8'(id_n));
        repeat (id_n) msg.push_back(8'($urandom_range(0, 255)));
      end
      for (int k = 0; k < type_n; k++) begin
        if (is_text || (k == 0 && $urandom_range(0, 1) == 0)) begin
          msg.push_back(TYPE_TEXT);
        end else begin
          msg.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (pay[k]) msg.push_back(pay[k]);
    end

    // The NDEF TLV itself, sometimes empty or claiming too much.
    ndef_len = msg.size();
    case ($urandom_range(0, 11))
      0: ndef_len = 0;
      1: ndef_len = ndef_len + $urandom_range(1, 300);
      default: begin
      end
    endcase
    tag_image.push_back(TLV_NDEF);
    if (ndef_len < 255 && $urandom_range(0, 3) != 0) begin
      tag_image.push_back(8'(ndef_len));
    end else begin
      tag_image.push_back(TLV_LEN_ESC);
      tag_image.push_back(8'(ndef_len >> 8));
      tag_image.push_back(8'(ndef_len));
    end
    foreach (msg[k]) tag_image.push_back(msg[k]);
    if ($urandom_range(0, 3) != 0) tag_image.push_back(TLV_TERM);
  endtask

  initial begin : stimulus
    int len;
    int n_buf;
    int fit;
    int ph;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bytes with no start mark while idle are dropped.
    offer_byte(8'hFF, 1'b0);
    offer_byte(TLV_NULL, 1'b0);

    // A zero buffer length drops everything.
    write_buffer_length(8'd0);
    offer_byte(TLV_NDEF, 1'b1);
    offer_byte(8'h00, 1'b0);

    // One short text record "Hi!" with language "en" after a null TLV.
    write_buffer_length(8'd14);
    tag_image = {TLV_NULL, TLV_NDEF, 8'h0A,
                 8'hD1,                       // MB, ME, SR, Well Known
                 8'h01, 8'h06, TYPE_TEXT,
                 8'h02, 8'h65, 8'h6E,         // status byte, "en"
                 8'h48, 8'h69, 8'h21,         // "Hi!"
                 TLV_TERM};
    send_image(14);

    // Random phases, each at one buffer length.
    ph = 0;
    bytes_sent = 0;
    while (bytes_sent < TARGET_BYTES) begin
      if (ph == 0) begin
        len = 255;
      end else if (ph == 1) begin
        len = 1;
      end else begin
        case ($urandom_range(0, 15))
          0: len = 0;
          1: len = 1;
          2: len = 255;
          default: len = $urandom_range(16, 100);
        endcase
      end
      ph++;
      write_buffer_length(8'(len));
      n_buf = (len == 255) ? 1 : $urandom_range(2, 5);

      repeat (n_buf) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: random bytes with a start mark.
          tag_image = {};
          repeat ($urandom_range(1, (len == 0) ? 4 : len + 4))
            tag_image.push_back(8'($urandom_range(0, 255)));
        end else begin
          build_ndef_image();
        end

        if (len == 0) begin
          if (tag_image.size() > 4) tag_image = tag_image[0:3];
        end else begin
          while (tag_image.size() < len) tag_image.push_back(8'($urandom_range(0, 255)));
          fit = $urandom_range(0, 7);
          if (fit == 0 && len > 1) begin
            // Cut short: the next start mark lands mid-buffer.
            tag_image = tag_image[0:$urandom_range(0, len - 2)];
          end else begin
            tag_image = tag_image[0:len - 1];
            // Bytes past the buffer length are dropped.
            if (fit == 1) begin
              repeat ($urandom_range(1, 3)) tag_image.push_back(8'($urandom_range(0, 255)));
            end
          end
        end
        send_image(len);

        // Stray bytes without a start mark.
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 2)) offer_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        if (bytes_sent >= QUIET_AFTER) quiet = 1'b1;
      end
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * 2_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ntre_pkg.sv
rtl/ntre_step.sv
rtl/ndef_text_record_extractor.sv
tb/ndef_text_record_extractor_checker.sv
tb/ndef_text_record_extractor_tb.sv
